[src/mbps_pkg.sv]
// Shared types, opcodes and the hex-character decoder for the masked byte pattern scanner.
// No dependencies; imported by every module of the block.
`default_nettype none

package mbps_pkg;

	// opcode field of an input word
	localparam logic [1:0] OP_CLEAR   = 2'd0;
	localparam logic [1:0] OP_APPEND  = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;
	localparam logic [1:0] OP_SEARCH  = 2'd3;

	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 8;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic       shift;   // new pattern byte enters at the tail, all cells move one down
		logic       wipe;    // drop the whole pattern
		logic       flush;   // drop every active prefix
		logic       search;  // compare the stream byte this cycle
		logic [7:0] data;
	} cell_ctrl_t;

	// one result word, found in the lowest bit
	typedef struct packed {
		logic overflow;
		logic found;
	} result_t;

	// returns {care, value}; non-hex characters give a wildcard with value 0
	function automatic logic [4:0] decode_nibble(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, 4'(c - 8'h30)};
		end else if (c >= 8'h41 && c <= 8'h46) begin
			r = {1'b1, 4'(c - 8'h41 + 8'h0a)};
		end else if (c >= 8'h61 && c <= 8'h66) begin
			r = {1'b1, 4'(c - 8'h61 + 8'h0a)};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[src/mbps_cell.sv]
// One cell of the scanner chain: a pattern byte, its nibble mask, a valid bit and
// an active-prefix bit. Depends on mbps_pkg.
`default_nettype none

module mbps_cell
	import mbps_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	// from the cell behind (toward the tail), used on a shift
	input  wire logic [7:0] nb_val,
	input  wire logic [7:0] nb_mask,
	input  wire logic       nb_vld,
	input  wire logic       nb_act,
	// low nibble write, only ever enabled on the tail cell
	input  wire logic       lo_wr,
	input  wire logic [3:0] lo_val,
	input  wire logic [3:0] lo_mask,
	// from the cell ahead (toward the head)
	input  wire logic       prev_vld,
	input  wire logic       prev_adv,
	output logic [7:0]      val,
	output logic [7:0]      mask,
	output logic            vld,
	output logic            act,
	output logic            adv
);

	logic [7:0] val_q;
	logic [7:0] mask_q;
	logic       vld_q;
	logic       act_q;
	logic       live;
	logic       match;

	assign match = ((ctrl.data ^ val_q) & mask_q) == 8'h00;
	// the first pattern byte is always live
	assign live  = act_q | (vld_q & ~prev_vld);
	assign adv   = vld_q & live & match;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			act_q <= 1'b0;
		end else begin
			if (ctrl.wipe) begin
				vld_q <= 1'b0;
			end else if (ctrl.shift) begin
				vld_q <= nb_vld;
			end
			if (ctrl.flush) begin
				act_q <= 1'b0;
			end else if (ctrl.search) begin
				act_q <= prev_adv;
			end else if (ctrl.shift) begin
				act_q <= nb_act;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			val_q  <= nb_val;
			mask_q <= nb_mask;
		end else if (lo_wr) begin
			val_q[3:0]  <= lo_val;
			mask_q[3:0] <= lo_mask;
		end
	end

	assign val  = val_q;
	assign mask = mask_q;
	assign vld  = vld_q;
	assign act  = act_q;

endmodule

`default_nettype wire

[src/mbps_out_buf.sv]
// Output register plus skid stage for result words.
// Depends on mbps_pkg (result_t).
`default_nettype none

module mbps_out_buf
	import mbps_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire result_t in_data,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    out_v_q;
	logic    skid_v_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign pop      = out_v_q & out_ready;
	assign in_ready = ~skid_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (in_valid) begin
			if (out_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (in_valid) begin
			if (out_v_q && !pop) begin
				skid_q <= in_data;
			end else begin
				out_q <= in_data;
			end
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid word held with empty output register");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && out_ready) |=> (out_v_q && !skid_v_q))
		else $error("skid word not moved to output on pop");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && out_v_q && !out_ready) |=> skid_v_q)
		else $error("accepted word lost while output stalled");

endmodule

`default_nettype wire

[src/masked_byte_pattern_scanner_unit.sv]
// Top level of the masked byte pattern scanner: command decode, the cell chain and
// the result buffer. Depends on mbps_pkg, mbps_cell and mbps_out_buf.
//
// Takes one word per clock and returns one result word per input word, registered
// in the output or, on a stall, the skid register; the input stalls only while
// two results wait on the output. The pattern is held right-aligned in a chain of
// MAX_PATTERN_BYTES cells, the last pattern byte always in the tail cell: a new
// pattern byte (high hex character) shifts the chain toward the head, a low
// character rewrites the tail cell. A search byte is compared in every cell at
// once and each live match hands its prefix bit to the next cell, so the rate is
// set by that combinational compare; found comes from the tail cell. Non-hex
// characters are wildcard nibbles; characters past 2*MAX_PATTERN_BYTES are
// dropped and reported as overflow.
`default_nettype none

module masked_byte_pattern_scanner_unit
	import mbps_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = 512
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,  // opcode[1:0], char_code[9:2], data_byte[17:10]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata   // found[0], overflow[1]
);

	localparam int N    = MAX_PATTERN_BYTES;
	localparam int CW   = $clog2(2 * N + 1);
	localparam logic [CW-1:0] FULL = CW'(2 * N);

	logic [1:0]    opcode;
	logic [7:0]    char_code;
	logic [7:0]    data_byte;
	logic          accept;
	logic          is_append;
	logic          full;
	logic [4:0]    nib;
	logic [CW-1:0] count_q;
	cell_ctrl_t    ctrl;
	logic          lo_wr;
	result_t       res;
	result_t       out_res;

	logic [7:0] val_w  [N];
	logic [7:0] mask_w [N];
	logic [N-1:0] vld_w;
	logic [N-1:0] act_w;
	logic [N-1:0] adv_w;

	assign opcode    = s_tdata[1:0];
	assign char_code = s_tdata[9:2];
	assign data_byte = s_tdata[17:10];

	assign accept    = s_tvalid & s_tready;
	assign full      = count_q == FULL;
	assign is_append = accept && (opcode == OP_APPEND);
	assign nib       = decode_nibble(char_code);

	always_comb begin
		ctrl        = '0;
		ctrl.data   = data_byte;
		lo_wr       = 1'b0;
		if (accept) begin
			case (opcode)
				OP_CLEAR: begin
					ctrl.wipe  = 1'b1;
					ctrl.flush = 1'b1;
				end
				OP_APPEND: begin
					ctrl.shift = ~full & ~count_q[0];
					lo_wr      = ~full & count_q[0];
				end
				OP_RESTART: begin
					ctrl.flush = 1'b1;
				end
				OP_SEARCH: begin
					ctrl.search = 1'b1;
				end
				default: begin
					ctrl.search = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && opcode == OP_CLEAR) begin
			count_q <= '0;
		end else if (is_append && !full) begin
			count_q <= count_q + 1'b1;
		end
	end

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_cell
			logic [7:0] nb_val;
			logic [7:0] nb_mask;
			logic       nb_vld;
			logic       nb_act;
			logic       prev_vld;
			logic       prev_adv;
			logic       cell_lo_wr;

			if (k == N - 1) begin : g_tail
				assign nb_val     = {nib[3:0], 4'h0};
				assign nb_mask    = {{4{nib[4]}}, 4'h0};
				assign nb_vld     = 1'b1;
				assign nb_act     = 1'b0;
				assign cell_lo_wr = lo_wr;
			end else begin : g_body
				assign nb_val     = val_w[k+1];
				assign nb_mask    = mask_w[k+1];
				assign nb_vld     = vld_w[k+1];
				assign nb_act     = act_w[k+1];
				assign cell_lo_wr = 1'b0;
			end

			if (k == 0) begin : g_head
				assign prev_vld = 1'b0;
				assign prev_adv = 1'b0;
			end else begin : g_mid
				assign prev_vld = vld_w[k-1];
				assign prev_adv = adv_w[k-1];
			end

			mbps_cell u_cell (
				.clk      (clk),
				.arst_n   (arst_n),
				.ctrl     (ctrl),
				.nb_val   (nb_val),
				.nb_mask  (nb_mask),
				.nb_vld   (nb_vld),
				.nb_act   (nb_act),
				.lo_wr    (cell_lo_wr),
				.lo_val   (nib[3:0]),
				.lo_mask  ({4{nib[4]}}),
				.prev_vld (prev_vld),
				.prev_adv (prev_adv),
				.val      (val_w[k]),
				.mask     (mask_w[k]),
				.vld      (vld_w[k]),
				.act      (act_w[k]),
				.adv      (adv_w[k])
			);

			if (k < N - 1) begin : g_chk
				a_tail_aligned: assert property (@(posedge clk) disable iff (!arst_n)
					vld_w[k] |-> vld_w[k+1])
					else $error("pattern cells not contiguous at the tail");
			end
		end
	endgenerate

	assign res.found    = ctrl.search & adv_w[N-1];
	assign res.overflow = is_append & full;

	mbps_out_buf u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_data   (res),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {{(OUT_DATA_W - 2){1'b0}}, out_res.overflow, out_res.found};

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("character count beyond capacity");

	a_len_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld_w) == ((32'(count_q) + 32'd1) >> 1))
		else $error("valid cells disagree with character count");

	a_overflow_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(is_append && full) |=> (count_q == $past(count_q)))
		else $error("dropped character changed the count");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_CLEAR) |=> (vld_w == '0 && act_w == '0))
		else $error("clear left pattern or prefixes behind");

endmodule

`default_nettype wire
